### rtl/multi_level_lru_locator_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the multi-level LRU locator
// Short forms for clocked assertions, with and without the reset qualifier.
// ----------------------------------------------------------------------------
`ifndef MULTI_LEVEL_LRU_LOCATOR_TOP_ASSERT_SVH
`define MULTI_LEVEL_LRU_LOCATOR_TOP_ASSERT_SVH

// Property checked only while out of reset.
`define MLLRU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define MLLRU_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/mllru_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mllru_pkg
// Shared constants, codes and types of the multi-level LRU locator.
// ----------------------------------------------------------------------------
package mllru_pkg;

    // Default sizing of the block.
    localparam int LEVELS_DEF      = 4;
    localparam int STACK_DEPTH_DEF = 1024;
    localparam int KEY_BITS_DEF    = 16;

    // Configuration register layout.
    localparam int LEVELS_IN_USE_W     = 3;
    localparam int LEVEL_SIZE_W        = 8;
    localparam int LEVEL_SIZE_MAX      = (1 << LEVEL_SIZE_W) - 1;
    localparam int REG_LEVELS_IN_USE   = 0;
    localparam int REG_LEVEL_SIZE_BASE = 1;
    localparam int APB_DATA_W          = 32;

    localparam logic [LEVELS_IN_USE_W-1:0] LEVELS_IN_USE_RST = 3'd4;
    localparam logic [LEVEL_SIZE_W-1:0]    LEVEL_SIZE_RST    = 8'd16;

    // Result kinds.
    localparam int RESULT_KIND_W = 2;
    localparam int LEVEL_OUT_W   = 2;
    localparam logic [RESULT_KIND_W-1:0] KIND_NEW     = 2'd0;
    localparam logic [RESULT_KIND_W-1:0] KIND_LEVEL   = 2'd1;
    localparam logic [RESULT_KIND_W-1:0] KIND_OUTSIDE = 2'd2;

    // Status of the seen map towards the sequencer.
    typedef struct packed {
        logic clearing;
        logic hit;
    } seen_stat_t;

endpackage

### rtl/mllru_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mllru_cfg_regs
// APB register file holding the level layout, and the derived level
// boundaries and total capacity.
// ----------------------------------------------------------------------------
module mllru_cfg_regs #(
    parameter int LEVELS      = mllru_pkg::LEVELS_DEF,
    parameter int STACK_DEPTH = mllru_pkg::STACK_DEPTH_DEF,
    parameter int FILL_W      = $clog2(STACK_DEPTH + 1),
    parameter int LIDX_W      = (LEVELS > 1) ? $clog2(LEVELS) : 1,
    parameter int PADDR_W     = $clog2(4 * (LEVELS + 1))
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [PADDR_W-1:0]                  paddr,
    input  logic [mllru_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [mllru_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready,
    output logic [FILL_W-1:0]                   edges [LEVELS],
    output logic [FILL_W-1:0]                   cap,
    output logic [LIDX_W-1:0]                   active_last
);
    import mllru_pkg::*;

    localparam int SUM_MAX = (LEVELS * LEVEL_SIZE_MAX > STACK_DEPTH) ?
                             LEVELS * LEVEL_SIZE_MAX : STACK_DEPTH;
    localparam int SUM_W   = $clog2(SUM_MAX + 1);
    localparam int IDX_W   = PADDR_W - 2;

    logic [LEVELS_IN_USE_W-1:0] levels_in_use_reg;
    logic [LEVEL_SIZE_W-1:0]    level_size_reg [LEVELS];
    logic [IDX_W-1:0]           reg_idx;
    logic                       wr_en;

    logic [FILL_W-1:0] edge_next [LEVELS];
    logic [FILL_W-1:0] edge_reg  [LEVELS];
    logic [FILL_W-1:0] cap_next;
    logic [FILL_W-1:0] cap_reg;
    logic [LIDX_W-1:0] active_last_next;
    logic [LIDX_W-1:0] active_last_reg;
    logic [SUM_W-1:0]  sum;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels_in_use_reg <= LEVELS_IN_USE_RST;
            for (int i = 0; i < LEVELS; i++)
            begin
                level_size_reg[i] <= LEVEL_SIZE_RST;
            end
        end
        else if (wr_en)
        begin
            if (int'(reg_idx) == REG_LEVELS_IN_USE)
            begin
                levels_in_use_reg <= pwdata[LEVELS_IN_USE_W-1:0];
            end
            for (int i = 0; i < LEVELS; i++)
            begin
                if (int'(reg_idx) == REG_LEVEL_SIZE_BASE + i)
                begin
                    level_size_reg[i] <= pwdata[LEVEL_SIZE_W-1:0];
                end
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        if (int'(reg_idx) == REG_LEVELS_IN_USE)
        begin
            prdata = APB_DATA_W'(levels_in_use_reg);
        end
        for (int i = 0; i < LEVELS; i++)
        begin
            if (int'(reg_idx) == REG_LEVEL_SIZE_BASE + i)
            begin
                prdata = APB_DATA_W'(level_size_reg[i]);
            end
        end
    end

    // Running level boundaries, saturated at the stack depth. A saturated
    // boundary still orders every legal depth correctly.
    always_comb
    begin
        sum = '0;
        for (int i = 0; i < LEVELS; i++)
        begin
            sum = sum + SUM_W'(level_size_reg[i]);
            edge_next[i] = (sum > SUM_W'(STACK_DEPTH)) ? FILL_W'(STACK_DEPTH)
                                                       : FILL_W'(sum);
        end

        if (levels_in_use_reg == '0)
        begin
            active_last_next = '0;
        end
        else if (int'(levels_in_use_reg) > LEVELS)
        begin
            active_last_next = LIDX_W'(LEVELS - 1);
        end
        else
        begin
            active_last_next = LIDX_W'(levels_in_use_reg - 1'b1);
        end

        cap_next = edge_next[active_last_next];
    end

    always_ff @(posedge clk)
    begin
        edge_reg        <= edge_next;
        cap_reg         <= cap_next;
        active_last_reg <= active_last_next;
    end

    assign edges       = edge_reg;
    assign cap         = cap_reg;
    assign active_last = active_last_reg;

endmodule

### rtl/mllru_seen_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mllru_seen_map
// One bit per key marking every key ever presented, with a clearing pass
// after reset.
// ----------------------------------------------------------------------------
module mllru_seen_map #(
    parameter int KEY_BITS = mllru_pkg::KEY_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  set_en,
    input  logic [KEY_BITS-1:0]   set_key,
    output mllru_pkg::seen_stat_t stat
);
    import mllru_pkg::*;

    localparam longint unsigned MAP_DEPTH = 64'd1 << KEY_BITS;

    logic                map_mem [MAP_DEPTH];
    logic [KEY_BITS-1:0] clr_addr_reg;
    logic                clearing_reg;
    logic                rd_bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (&clr_addr_reg)
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // The lookup returns the old bit while the same edge marks the key.
    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            map_mem[clr_addr_reg] <= 1'b0;
        end
        else if (set_en)
        begin
            map_mem[set_key] <= 1'b1;
        end
        if (set_en)
        begin
            rd_bit_reg <= map_mem[set_key];
        end
    end

    assign stat.clearing = clearing_reg;
    assign stat.hit      = rd_bit_reg;

endmodule

### rtl/mllru_stack_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mllru_stack_mem
// Recency stack storage: one write port and one registered read port.
// ----------------------------------------------------------------------------
module mllru_stack_mem #(
    parameter int DEPTH  = mllru_pkg::STACK_DEPTH_DEF,
    parameter int WIDTH  = mllru_pkg::KEY_BITS_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);
    import mllru_pkg::*;

    logic [WIDTH-1:0] stack_mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            stack_mem[waddr] <= wdata;
        end
        rdata_reg <= stack_mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/multi_level_lru_locator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_level_lru_locator_top
// Multi-level LRU stack-distance locator with an APB configuration port.
// ----------------------------------------------------------------------------
// Each input beat carries a key and a report flag. The block looks the key up
// in a most-recently-used stack, moves it to the top and returns one output
// beat telling where the key stood before the move: new, inside a level
// (with the level number), or seen before but deeper than the total capacity.
// With report low the result is always "new", but the stack is still updated.
// The stack is walked entry by entry through its single read port while the
// entries above the key are pushed down one place behind the read: the item
// is accepted, each entry is visited up to and including the match (or the
// whole fill when the key is absent), and the result is then handed over.
// One item is worked on at a time; the next beat is taken as soon as the
// result has been moved to the output register, even if that result has not
// been collected yet. After reset the seen map is swept clear, one key per
// cycle, during which no input beat is accepted; configuration writes are
// taken throughout. Configuration must only be written while the block is
// idle.
// ----------------------------------------------------------------------------
module multi_level_lru_locator_top #(
    parameter int LEVELS      = mllru_pkg::LEVELS_DEF,
    parameter int STACK_DEPTH = mllru_pkg::STACK_DEPTH_DEF,
    parameter int KEY_BITS    = mllru_pkg::KEY_BITS_DEF,
    parameter int PADDR_W     = $clog2(4 * (LEVELS + 1))
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Input channel
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [KEY_BITS-1:0]                   key,
    input  logic                                  report,
    // Output channel
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [mllru_pkg::RESULT_KIND_W-1:0]   result_kind,
    output logic [mllru_pkg::LEVEL_OUT_W-1:0]     level,
    // Configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [PADDR_W-1:0]                    paddr,
    input  logic [mllru_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [mllru_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                  pready
);
    import mllru_pkg::*;

    localparam int FILL_W = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int LIDX_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;

    // Sequencer states, one-hot.
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_RESP = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Configuration-derived values.
    logic [FILL_W-1:0] edges [LEVELS];
    logic [FILL_W-1:0] cap;
    logic [LIDX_W-1:0] active_last;

    // Seen map.
    seen_stat_t seen_stat;
    logic       in_fire;

    // Stack memory port.
    logic                stk_we;
    logic [ADDR_W-1:0]   stk_waddr;
    logic [ADDR_W-1:0]   stk_raddr;
    logic [KEY_BITS-1:0] stk_rdata;

    // Item context.
    logic [KEY_BITS-1:0] key_reg;
    logic                report_reg;
    logic [KEY_BITS-1:0] carry_reg;
    logic [KEY_BITS-1:0] carry_next;
    logic [FILL_W-1:0]   pos_reg;
    logic [FILL_W-1:0]   pos_next;
    logic [FILL_W-1:0]   pos_inc;
    logic [FILL_W-1:0]   fill_reg;
    logic [FILL_W-1:0]   fill_next;

    // Walk decisions.
    logic              at_end;
    logic              match;
    logic              walk_done;
    logic              lvl_hit;
    logic [LIDX_W-1:0] lvl_idx;

    // Pending result and output register.
    logic [RESULT_KIND_W-1:0] kind_reg;
    logic [RESULT_KIND_W-1:0] kind_next;
    logic [LEVEL_OUT_W-1:0]   lvl_reg;
    logic [LEVEL_OUT_W-1:0]   lvl_next;
    logic                     out_valid_reg;
    logic [RESULT_KIND_W-1:0] out_kind_reg;
    logic [LEVEL_OUT_W-1:0]   out_lvl_reg;
    logic                     out_load;

    mllru_cfg_regs #(
        .LEVELS      (LEVELS),
        .STACK_DEPTH (STACK_DEPTH),
        .FILL_W      (FILL_W),
        .LIDX_W      (LIDX_W),
        .PADDR_W     (PADDR_W)
    ) u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .edges       (edges),
        .cap         (cap),
        .active_last (active_last)
    );

    // The seen bit of the accepted key arrives in the next cycle and holds for
    // the rest of the item; the key is marked at the same edge.
    mllru_seen_map #(
        .KEY_BITS (KEY_BITS)
    ) u_seen (
        .clk     (clk),
        .rst_n   (rst_n),
        .set_en  (in_fire),
        .set_key (key),
        .stat    (seen_stat)
    );

    mllru_stack_mem #(
        .DEPTH  (STACK_DEPTH),
        .WIDTH  (KEY_BITS),
        .ADDR_W (ADDR_W)
    ) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (carry_reg),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    assign in_ready = (state_reg == ST_IDLE) && !seen_stat.clearing;
    assign in_fire  = in_valid && in_ready;
    assign out_load = (state_reg == ST_RESP) && (!out_valid_reg || out_ready);

    // The walk reads entry pos+1 while entry pos, just returned by the
    // memory, is compared with the key and overwritten with the carried
    // entry. The carry starts as the key itself, so a hit at depth d leaves
    // the key on top and the d entries above it pushed down one place.
    always_comb
    begin
        pos_inc   = pos_reg + 1'b1;
        at_end    = (pos_reg == fill_reg);
        match     = !at_end && seen_stat.hit && (stk_rdata == key_reg);
        walk_done = at_end || match;

        // An absent key is pushed: the carried bottom entry lands just past
        // the fill if there is room, and falls off otherwise.
        stk_we    = (state_reg == ST_WALK) && (!at_end || (fill_reg < cap));
        stk_waddr = pos_reg[ADDR_W-1:0];

        if (state_reg == ST_WALK)
        begin
            stk_raddr = (pos_inc < FILL_W'(STACK_DEPTH)) ? pos_inc[ADDR_W-1:0] : '0;
        end
        else
        begin
            stk_raddr = '0;
        end

        // Level that holds the matching depth; the lowest level wins.
        lvl_hit = 1'b0;
        lvl_idx = '0;
        for (int i = LEVELS - 1; i >= 0; i--)
        begin
            if ((LIDX_W'(i) <= active_last) && (pos_reg < edges[i]))
            begin
                lvl_hit = 1'b1;
                lvl_idx = LIDX_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        carry_next = carry_reg;
        pos_next   = pos_reg;
        fill_next  = fill_reg;
        kind_next  = kind_reg;
        lvl_next   = lvl_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    // A capacity shrunk by configuration cuts the stack here.
                    fill_next  = (fill_reg > cap) ? cap : fill_reg;
                    carry_next = key;
                    pos_next   = '0;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (walk_done)
                begin
                    state_next = ST_RESP;
                    kind_next  = KIND_NEW;
                    lvl_next   = '0;
                    if (match)
                    begin
                        if (report_reg)
                        begin
                            kind_next = lvl_hit ? KIND_LEVEL : KIND_OUTSIDE;
                            lvl_next  = lvl_hit ? LEVEL_OUT_W'(lvl_idx) : '0;
                        end
                    end
                    else
                    begin
                        if (report_reg && seen_stat.hit)
                        begin
                            kind_next = KIND_OUTSIDE;
                        end
                        if (fill_reg < cap)
                        begin
                            fill_next = fill_reg + 1'b1;
                        end
                    end
                end
                else
                begin
                    carry_next = stk_rdata;
                    pos_next   = pos_inc;
                end
            end
            ST_RESP:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            pos_reg   <= pos_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Item payload and result registers.
    always_ff @(posedge clk)
    begin
        carry_reg <= carry_next;
        kind_reg  <= kind_next;
        lvl_reg   <= lvl_next;
        if (in_fire)
        begin
            key_reg    <= key;
            report_reg <= report;
        end
        if (out_load)
        begin
            out_kind_reg <= kind_reg;
            out_lvl_reg  <= lvl_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = out_kind_reg;
    assign level       = out_lvl_reg;

endmodule

### rtl/mllru_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mllru_checker
// Port-level checks of the multi-level LRU locator, bound to the top level.
// ----------------------------------------------------------------------------
`include "multi_level_lru_locator_top_assert.svh"

module mllru_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic [mllru_pkg::RESULT_KIND_W-1:0] result_kind,
    input logic [mllru_pkg::LEVEL_OUT_W-1:0]   level
);
    import mllru_pkg::*;

    // Only one item is in work, so an accepted beat closes the input side.
    `MLLRU_ASSERT(a_one_item, in_valid && in_ready |=> !in_ready, "input taken while busy")

    // A stalled result holds its value.
    `MLLRU_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(result_kind) && $stable(level), "result changed while stalled")

    // Only the three defined kinds are ever returned.
    `MLLRU_ASSERT(a_kind_legal, out_valid |-> (result_kind == KIND_NEW) || (result_kind == KIND_LEVEL) || (result_kind == KIND_OUTSIDE), "illegal result kind")

    // A level is reported only for a hit inside a level.
    `MLLRU_ASSERT(a_level_zero, out_valid && (result_kind != KIND_LEVEL) |-> level == '0, "level set without a level hit")

    // Once reset has been seen at an edge, nothing is offered or taken at the
    // next one, whether reset is still held or has just been released.
    `MLLRU_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid && !in_ready, "handshake active in reset")

endmodule

bind multi_level_lru_locator_top mllru_checker u_mllru_checker (.*);
